/* design/lr_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Line rasterizer package
// Shared widths, codes, the result type and the coordinate step helper.
// ----------------------------------------------------------------------------
package lr_pkg;

  localparam int unsigned SCREEN_WIDTH_DEF  = 480;
  localparam int unsigned SCREEN_HEIGHT_DEF = 272;

  localparam int unsigned COORD_W = 10;
  localparam int unsigned ERR_W   = 12;
  localparam int unsigned COLOR_W = 16;
  localparam int unsigned WORD_W  = 16;
  localparam int unsigned FRAME_W = 2;

  typedef enum logic {
    MODE_LOAD = 1'b0,
    MODE_STEP = 1'b1
  } mode_t;

  localparam logic [FRAME_W-1:0] FRAME_RESET  = 2'd1;
  localparam logic [FRAME_W-1:0] FRAME_UNUSED = 2'd3;

  typedef struct packed {
    logic [COORD_W-1:0] x;
    logic [COORD_W-1:0] y;
    logic [WORD_W-1:0]  word;
    logic               upper;
    logic [COLOR_W-1:0] color;
    logic [FRAME_W-1:0] frame;
    logic               off;
    logic               last;
  } pixel_t;

  function automatic logic [COORD_W-1:0] move_coord(input logic [COORD_W-1:0] c,
                                                     input logic down);
    move_coord = down ? c - COORD_W'(1) : c + COORD_W'(1);
  endfunction

endpackage
`default_nettype wire

/* design/line_rasterizer_unit.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Line rasterizer unit
// Bresenham line generator in all eight octants, one pixel per step item.
//
// Input channel (in_valid / in_stall): mode 0 loads both endpoints and the
// colour of a new line and yields no pixel; mode 1 yields the next pixel of
// the active line, or nothing when no line is active. A load drops any line
// still in progress.
// Output channel (out_valid / out_stall): one pixel with its position,
// framebuffer word index, half-word select, colour, frame, off-screen and
// last-pixel flags. Every pixel is held in the result register.
// Throughput is one item per cycle while in_stall is low, set by the single
// add-compare update of the error term and coordinates in the stepper.
// A stalled receiver holds the result register; one more pixel lands in a
// skid entry, and only then does in_stall rise.
// cfg_valid / cfg_ready writes the frame select; ready is always high and
// the unused code 3 is dropped. Reset idles the line and selects frame 1.
// ----------------------------------------------------------------------------
module line_rasterizer_unit #(
  parameter int unsigned SCREEN_WIDTH  = lr_pkg::SCREEN_WIDTH_DEF,
  parameter int unsigned SCREEN_HEIGHT = lr_pkg::SCREEN_HEIGHT_DEF
) (
  input  wire logic                       clk,
  input  wire logic                       rst,
  input  wire logic                       cfg_valid,
  output logic                            cfg_ready,
  input  wire logic [lr_pkg::FRAME_W-1:0] cfg_data,
  input  wire logic                       in_valid,
  output logic                            in_stall,
  input  wire logic                       mode,
  input  wire logic [lr_pkg::COORD_W-1:0] start_x,
  input  wire logic [lr_pkg::COORD_W-1:0] start_y,
  input  wire logic [lr_pkg::COORD_W-1:0] end_x,
  input  wire logic [lr_pkg::COORD_W-1:0] end_y,
  input  wire logic [lr_pkg::COLOR_W-1:0] pixel_color,
  output logic                            out_valid,
  input  wire logic                       out_stall,
  output logic [lr_pkg::COORD_W-1:0]      pixel_x,
  output logic [lr_pkg::COORD_W-1:0]      pixel_y,
  output logic [lr_pkg::WORD_W-1:0]       word_index,
  output logic                            upper_half,
  output logic [lr_pkg::COLOR_W-1:0]      color_out,
  output logic [lr_pkg::FRAME_W-1:0]      frame_id,
  output logic                            off_screen,
  output logic                            last_pixel
);

  logic [lr_pkg::FRAME_W-1:0] frame_choice;
  logic                       take;
  logic                       res_valid;
  lr_pkg::pixel_t             res;
  lr_pkg::pixel_t             out_data;
  logic                       buf_full;

  assign cfg_ready = 1'b1;
  assign in_stall  = buf_full;
  assign take      = in_valid && !buf_full;

  always_ff @(posedge clk) begin
    if (rst) begin
      frame_choice <= lr_pkg::FRAME_RESET;
    end else if (cfg_valid && cfg_ready && (cfg_data != lr_pkg::FRAME_UNUSED)) begin
      frame_choice <= cfg_data;
    end
  end

  lr_stepper #(
    .SCREEN_WIDTH (SCREEN_WIDTH),
    .SCREEN_HEIGHT(SCREEN_HEIGHT)
  ) u_stepper (
    .clk        (clk),
    .rst        (rst),
    .take       (take),
    .mode       (mode),
    .start_x    (start_x),
    .start_y    (start_y),
    .end_x      (end_x),
    .end_y      (end_y),
    .pixel_color(pixel_color),
    .frame      (frame_choice),
    .res_valid  (res_valid),
    .res        (res)
  );

  lr_out_buffer u_out (
    .clk      (clk),
    .rst      (rst),
    .push     (res_valid),
    .push_data(res),
    .full     (buf_full),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_data (out_data)
  );

  assign pixel_x    = out_data.x;
  assign pixel_y    = out_data.y;
  assign word_index = out_data.word;
  assign upper_half = out_data.upper;
  assign color_out  = out_data.color;
  assign frame_id   = out_data.frame;
  assign off_screen = out_data.off;
  assign last_pixel = out_data.last;

endmodule
`default_nettype wire

/* design/lr_pixel_map.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Line rasterizer pixel map
// Screen bounds check and framebuffer word index for one pixel position.
// ----------------------------------------------------------------------------
module lr_pixel_map #(
  parameter int unsigned SCREEN_WIDTH  = lr_pkg::SCREEN_WIDTH_DEF,
  parameter int unsigned SCREEN_HEIGHT = lr_pkg::SCREEN_HEIGHT_DEF
) (
  input  wire logic [lr_pkg::COORD_W-1:0] x,
  input  wire logic [lr_pkg::COORD_W-1:0] y,
  output logic                            off,
  output logic [lr_pkg::WORD_W-1:0]       word
);

  localparam int unsigned CMP_W  = lr_pkg::COORD_W + 1;
  localparam int unsigned PROD_W = 2 * lr_pkg::COORD_W;
  localparam int unsigned HALF_W = SCREEN_WIDTH / 2;

  logic [PROD_W-1:0] prod;

  always_comb begin
    off  = ({1'b0, x} >= CMP_W'(SCREEN_WIDTH)) || ({1'b0, y} >= CMP_W'(SCREEN_HEIGHT));
    prod = PROD_W'(y) * PROD_W'(HALF_W) + PROD_W'(x >> 1);
    word = off ? '0 : prod[lr_pkg::WORD_W-1:0];
  end

endmodule
`default_nettype wire

/* design/lr_stepper.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Line rasterizer stepper
// Holds the line state, sets it up on load and advances it one pixel per step.
// ----------------------------------------------------------------------------
module lr_stepper #(
  parameter int unsigned SCREEN_WIDTH  = lr_pkg::SCREEN_WIDTH_DEF,
  parameter int unsigned SCREEN_HEIGHT = lr_pkg::SCREEN_HEIGHT_DEF
) (
  input  wire logic                            clk,
  input  wire logic                            rst,
  input  wire logic                            take,
  input  wire logic                            mode,
  input  wire logic [lr_pkg::COORD_W-1:0]      start_x,
  input  wire logic [lr_pkg::COORD_W-1:0]      start_y,
  input  wire logic [lr_pkg::COORD_W-1:0]      end_x,
  input  wire logic [lr_pkg::COORD_W-1:0]      end_y,
  input  wire logic [lr_pkg::COLOR_W-1:0]      pixel_color,
  input  wire logic [lr_pkg::FRAME_W-1:0]      frame,
  output logic                                 res_valid,
  output lr_pkg::pixel_t                       res
);

  localparam int unsigned CW = lr_pkg::COORD_W;
  localparam int unsigned EW = lr_pkg::ERR_W;

  logic                        busy;
  logic [CW-1:0]               cur_x;
  logic [CW-1:0]               cur_y;
  logic [CW-1:0]               stop_coord;
  logic signed [EW-1:0]        err_term;
  logic [CW-1:0]               delta_major;
  logic [CW-1:0]               delta_minor;
  logic                        x_is_major;
  logic                        x_goes_down;
  logic                        y_goes_down;
  logic [lr_pkg::COLOR_W-1:0]  line_color;

  logic [CW-1:0]               adx;
  logic [CW-1:0]               ady;
  logic                        ld_x_major;
  logic [CW-1:0]               ld_major;
  logic [CW-1:0]               ld_minor;
  logic signed [EW-1:0]        ld_err;

  logic                        map_off;
  logic [lr_pkg::WORD_W-1:0]   map_word;
  logic                        last;
  logic                        minor_move;
  logic signed [EW-1:0]        err_adj;
  logic signed [EW-1:0]        err_next;
  logic [CW-1:0]               x_next;
  logic [CW-1:0]               y_next;
  logic                        do_load;
  logic                        do_step;

  lr_pixel_map #(
    .SCREEN_WIDTH (SCREEN_WIDTH),
    .SCREEN_HEIGHT(SCREEN_HEIGHT)
  ) u_map (
    .x   (cur_x),
    .y   (cur_y),
    .off (map_off),
    .word(map_word)
  );

  always_comb begin
    do_load = take && (mode == lr_pkg::MODE_LOAD);
    do_step = take && (mode == lr_pkg::MODE_STEP) && busy;

    adx        = (end_x >= start_x) ? end_x - start_x : start_x - end_x;
    ady        = (end_y >= start_y) ? end_y - start_y : start_y - end_y;
    ld_x_major = adx >= ady;
    ld_major   = ld_x_major ? adx : ady;
    ld_minor   = ld_x_major ? ady : adx;
    ld_err     = signed'(EW'(ld_minor)) - signed'(EW'(ld_major >> 1));

    last       = (x_is_major ? cur_x : cur_y) == stop_coord;
    minor_move = err_term > 0;
    err_adj    = minor_move ? err_term - signed'(EW'(delta_major)) : err_term;
    err_next   = err_adj + signed'(EW'(delta_minor));

    x_next = cur_x;
    y_next = cur_y;
    if (x_is_major) begin
      x_next = lr_pkg::move_coord(cur_x, x_goes_down);
      if (minor_move) begin
        y_next = lr_pkg::move_coord(cur_y, y_goes_down);
      end
    end else begin
      y_next = lr_pkg::move_coord(cur_y, y_goes_down);
      if (minor_move) begin
        x_next = lr_pkg::move_coord(cur_x, x_goes_down);
      end
    end

    res_valid = do_step;
    res.x     = cur_x;
    res.y     = cur_y;
    res.word  = map_word;
    res.upper = ~cur_x[0];
    res.color = line_color;
    res.frame = frame;
    res.off   = map_off;
    res.last  = last;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy        <= 1'b0;
      cur_x       <= '0;
      cur_y       <= '0;
      stop_coord  <= '0;
      err_term    <= '0;
      delta_major <= '0;
      delta_minor <= '0;
      x_is_major  <= 1'b0;
      x_goes_down <= 1'b0;
      y_goes_down <= 1'b0;
      line_color  <= '0;
    end else if (do_load) begin
      busy        <= 1'b1;
      cur_x       <= start_x;
      cur_y       <= start_y;
      stop_coord  <= ld_x_major ? end_x : end_y;
      err_term    <= ld_err;
      delta_major <= ld_major;
      delta_minor <= ld_minor;
      x_is_major  <= ld_x_major;
      x_goes_down <= end_x < start_x;
      y_goes_down <= end_y < start_y;
      line_color  <= pixel_color;
    end else if (do_step) begin
      if (last) begin
        busy <= 1'b0;
      end else begin
        cur_x    <= x_next;
        cur_y    <= y_next;
        err_term <= err_next;
      end
    end
  end

endmodule
`default_nettype wire

/* design/lr_out_buffer.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Line rasterizer output buffer
// Result register with a skid entry so a stalled receiver stops intake only once the skid entry is full.
// ----------------------------------------------------------------------------
module lr_out_buffer (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire logic           push,
  input  wire lr_pkg::pixel_t push_data,
  output logic                full,
  output logic                out_valid,
  input  wire logic           out_stall,
  output lr_pkg::pixel_t      out_data
);

  logic           skid_valid;
  lr_pkg::pixel_t skid_data;
  logic           out_open;

  assign out_open = !out_valid || !out_stall;
  assign full     = skid_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else begin
      if (out_open) begin
        out_valid <= skid_valid || push;
      end
      if (skid_valid) begin
        if (!out_stall) begin
          skid_valid <= 1'b0;
        end
      end else if (push && !out_open) begin
        skid_valid <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (out_open) begin
      out_data <= skid_valid ? skid_data : push_data;
    end
    if (!skid_valid && push && !out_open) begin
      skid_data <= push_data;
    end
  end

endmodule
`default_nettype wire
